// File: hw/rtl/isp_pkg.sv
// Shared constants and codes for the interpolating sample player.
`default_nettype none

package isp_pkg;

    // Default sizes
    localparam int DEF_SAMPLE_DEPTH = 65536;
    localparam int DEF_FRAC_BITS    = 16;

    // Field widths fixed by the item format
    localparam int ACTION_W  = 2;
    localparam int ADDR_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int CTRL_W    = 7;
    localparam int PCM_W     = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_SAMPLE_LENGTH = 1'b0;
    localparam t_cfg_idx REG_LOOP_ENABLE   = 1'b1;

    // Reset value of the sample length register
    localparam int LEN_RST = 65536;

    // Action codes
    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_LOAD   = 2'd0;
    localparam t_action ACT_RENDER = 2'd1;
    localparam t_action ACT_NOTE   = 2'd2;
    localparam t_action ACT_PITCH  = 2'd3;

    // Event thresholds
    localparam logic [CTRL_W-1:0] VEL_ON     = 7'd64;
    localparam logic [CTRL_W-1:0] PITCH_KNEE = 7'd64;
    localparam int PITCH_LOW_ENTRIES = 65;   // pitch values 0..64
    localparam int PITCH_LOW_BIAS    = 63;
    localparam int PITCH_LOW_DIV     = 127;
    localparam int PITCH_HIGH_SHIFT  = 6;    // divide by 64

    // Output stage
    localparam int PCM_SCALE_SHIFT = 15;     // 32767 = 2^15 - 1
    localparam int OUT_Q_DEPTH     = 4;

endpackage

`default_nettype wire

// File: hw/rtl/interpolating_sample_player_top.sv
// Top level of the interpolating sample player.
`default_nettype none

// Interpolating sample player. Sample words live in one RAM with a write port and a
// registered read port (SAMPLE_DEPTH entries, a power of two); a load transaction writes
// one word in its own cycle. A render transaction reads the word at the integer part of
// the 16.16 play position and the word after it, blends them on the fraction, scales by
// 5, adds i_mix_in, clips to +-1.0 and returns one PCM transaction. Each render reads
// the single RAM read port twice, once per word; loads, note and pitch transactions do
// not hold off input. A render's result passes the blend, accumulator and clipped
// magnitude registers into a four-entry output queue, which raises o_out_valid and holds
// results while the output stalls. Input is held off while a render makes its second
// read and whenever four renders are outstanding. Note
// transactions with velocity 64 or above start playback, below 64 they stop and rewind.
// Pitch transactions set the step. Write the configuration registers only while no
// transaction is in flight. Reading a sample word that was never loaded returns undefined
// audio.

module interpolating_sample_player_top #(
    parameter int SAMPLE_DEPTH = isp_pkg::DEF_SAMPLE_DEPTH,
    parameter int FRAC_BITS    = isp_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic        [isp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic        [isp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic        [isp_pkg::ACTION_W-1:0]   i_action,
    input  wire logic        [isp_pkg::ADDR_W-1:0]     i_load_address,
    input  wire logic signed [isp_pkg::SAMPLE_W-1:0]   i_sample_word,
    input  wire logic        [isp_pkg::CTRL_W-1:0]     i_control_value,
    input  wire logic signed [isp_pkg::SAMPLE_W-1:0]   i_mix_in,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed      [isp_pkg::PCM_W-1:0]      o_pcm_out
);

    import isp_pkg::*;

    localparam int AW   = $clog2(SAMPLE_DEPTH);
    localparam int F    = FRAC_BITS;
    localparam int PS   = AW + F;                 // play position width
    localparam int SW   = F + 1;                  // step width, below 2.0
    localparam int LW   = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;
    localparam int PW   = F + 17;                 // blend width
    localparam int ACCW = F + 20;                 // accumulator width
    localparam int MW   = F + 16;                 // clipped magnitude width
    localparam int SCW  = MW + PCM_SCALE_SHIFT;   // scaled magnitude width
    localparam int QAW  = $clog2(OUT_Q_DEPTH);
    localparam int CNTW = QAW + 1;
    localparam int PIW  = $clog2(PITCH_LOW_ENTRIES);

    localparam int LEN_RST_EFF = (SAMPLE_DEPTH < LEN_RST) ? SAMPLE_DEPTH : LEN_RST;
    localparam logic [PS-1:0] END_RST  = PS'(LEN_RST_EFF - 1) << F;
    localparam logic [SW-1:0] STEP_RST = {1'b1, {F{1'b0}}};
    localparam logic signed [ACCW-1:0] LIM = ACCW'(1) <<< (PCM_SCALE_SHIFT + F);

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic            r_v1;          // render in first read cycle
    logic            r_v2;          // render in second read cycle
    logic            r_v3;          // blend valid
    logic            r_v4;          // accumulator valid
    logic            r_v5;          // clipped magnitude valid
    logic [CNTW-1:0] r_cnt;         // renders accepted and not yet delivered

    logic in_acc;
    logic out_acc;
    logic is_render;

    assign o_in_ready = !r_v1 && (r_cnt < CNTW'(OUT_Q_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_render  = in_acc && (t_action'(i_action) == ACT_RENDER);

    // ------------------------------------------------------------------
    // Configuration: keep the end point precomputed
    // ------------------------------------------------------------------
    logic [PS-1:0] r_end;
    logic          r_loop;
    logic [LW-1:0] cfg_len;
    logic [LW-1:0] cfg_len_m1;
    logic [PS-1:0] n_end;

    always_comb begin
        cfg_len = LW'(i_cfg_data);
        priority if (cfg_len < LW'(2)) begin
            cfg_len = LW'(2);
        end else if (cfg_len > LW'(SAMPLE_DEPTH)) begin
            cfg_len = LW'(SAMPLE_DEPTH);
        end
        cfg_len_m1 = cfg_len - LW'(1);
        n_end      = {cfg_len_m1[AW-1:0], {F{1'b0}}};
    end

    // ------------------------------------------------------------------
    // Pitch table for values 0..64: (63 + v) / 127 in fixed point
    // ------------------------------------------------------------------
    logic [SW-1:0] pitch_low [PITCH_LOW_ENTRIES];

    for (genvar gi = 0; gi < PITCH_LOW_ENTRIES; gi++) begin : g_pitch
        assign pitch_low[gi] =
            SW'((64'(PITCH_LOW_BIAS + gi) << F) / 64'(PITCH_LOW_DIV));
    end

    // ------------------------------------------------------------------
    // Playback state and position update
    // ------------------------------------------------------------------
    logic [PS-1:0] r_pos;
    logic [SW-1:0] r_step;
    logic          r_playing;

    logic [PS:0]   pos_sum;
    logic [PS:0]   pos_wrap;
    logic [PS-1:0] n_pos;
    logic          n_playing;
    logic [SW-1:0] n_step;

    assign pos_sum  = {1'b0, r_pos} + (PS + 1)'(r_step);
    assign pos_wrap = pos_sum - {1'b0, r_end};

    always_comb begin
        n_pos     = r_pos;
        n_playing = r_playing;
        n_step    = r_step;
        if (in_acc) begin
            unique case (t_action'(i_action))
                ACT_RENDER: begin
                    if (r_playing) begin
                        priority if (pos_sum < {1'b0, r_end}) begin
                            n_pos = pos_sum[PS-1:0];
                        end else if (r_loop) begin
                            n_pos = pos_wrap[PS-1:0];
                        end else begin
                            n_pos     = '0;
                            n_playing = 1'b0;
                        end
                    end
                end
                ACT_NOTE: begin
                    if (i_control_value >= VEL_ON) begin
                        n_playing = 1'b1;
                    end else begin
                        n_playing = 1'b0;
                        n_pos     = '0;
                    end
                end
                ACT_PITCH: begin
                    if (i_control_value > PITCH_KNEE) begin
                        n_step = {i_control_value, {(F - PITCH_HIGH_SHIFT){1'b0}}};
                    end else begin
                        n_step = pitch_low[i_control_value[PIW-1:0]];
                    end
                end
                default: begin
                    // load: store write only
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sample store
    // ------------------------------------------------------------------
    logic [AW-1:0]       r_idx1;
    logic [AW-1:0]       pos_idx;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                ram_we;

    assign pos_idx   = r_pos[PS-1:F];
    assign ram_raddr = r_v1 ? r_idx1 : pos_idx;
    assign ram_we    = in_acc && (t_action'(i_action) == ACT_LOAD);

    isp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_load_address)),
        .i_wdata (i_sample_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath: blend, scale and mix, clip, convert
    // ------------------------------------------------------------------
    logic        [F-1:0]        r_s1_f;
    logic signed [SAMPLE_W-1:0] r_s1_mix;
    logic                       r_s1_play;
    logic        [F-1:0]        r_s2_f;
    logic signed [SAMPLE_W-1:0] r_s2_mix;
    logic                       r_s2_play;
    logic signed [PW-1:0]       r_p0;
    logic signed [PW-1:0]       r_p;
    logic signed [SAMPLE_W-1:0] r_s3_mix;
    logic signed [ACCW-1:0]     r_acc;
    logic        [MW-1:0]       r_mag;
    logic                       r_neg;

    logic        [F:0]          one_minus_f;
    logic signed [PW:0]         prod0;
    logic signed [PW-1:0]       prod1;
    logic signed [ACCW-1:0]     p_ext;
    logic signed [ACCW-1:0]     acc_sum;
    logic signed [ACCW-1:0]     acc_abs;
    logic        [MW-1:0]       mag_clip;
    logic        [SCW-1:0]      scaled;
    logic        [PCM_W-1:0]    pcm_mag;
    logic        [PCM_W-1:0]    pcm_val;

    assign one_minus_f = {1'b1, {F{1'b0}}} - {1'b0, r_s1_f};
    assign prod0 = $signed(ram_rdata) * $signed({1'b0, one_minus_f});
    assign prod1 = $signed(ram_rdata) * $signed({1'b0, r_s2_f});

    // times 5 is a shift and add; mix sits at the fraction point
    assign p_ext   = ACCW'(r_p);
    assign acc_sum = (p_ext <<< 2) + p_ext + (ACCW'(r_s3_mix) <<< F);

    assign acc_abs  = r_acc[ACCW-1] ? -r_acc : r_acc;
    assign mag_clip = (acc_abs > LIM) ? MW'(LIM) : MW'(acc_abs);

    // times 32767 as (m << 15) - m, then drop 15 + F bits
    assign scaled  = {r_mag, {PCM_SCALE_SHIFT{1'b0}}} - SCW'(r_mag);
    assign pcm_mag = scaled[SCW-1:SCW-PCM_W];
    assign pcm_val = r_neg ? -pcm_mag : pcm_mag;

    always_ff @(posedge i_clk) begin
        // accept: capture fraction and mix, launch first read
        if (is_render) begin
            r_s1_f    <= r_pos[F-1:0];
            r_s1_mix  <= i_mix_in;
            r_s1_play <= r_playing;
            r_idx1    <= pos_idx + AW'(1);
        end
        // first word back: weight it, launch second read
        if (r_v1) begin
            r_p0      <= r_s1_play ? PW'(prod0) : '0;
            r_s2_f    <= r_s1_f;
            r_s2_mix  <= r_s1_mix;
            r_s2_play <= r_s1_play;
        end
        // second word back: complete the blend
        if (r_v2) begin
            r_p      <= r_s2_play ? (r_p0 + prod1) : '0;
            r_s3_mix <= r_s2_mix;
        end
        if (r_v3) begin
            r_acc <= acc_sum;
        end
        if (r_v4) begin
            r_mag <= mag_clip;
            r_neg <= r_acc[ACCW-1];
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [PCM_W-1:0] r_q [OUT_Q_DEPTH];
    logic [QAW:0]     r_wp;
    logic [QAW:0]     r_rp;

    assign o_out_valid = (r_wp != r_rp);
    assign o_pcm_out   = r_q[r_rp[QAW-1:0]];
    assign out_acc     = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (r_v5) begin
            r_q[r_wp[QAW-1:0]] <= pcm_val;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_cnt     <= '0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_pos     <= '0;
            r_step    <= STEP_RST;
            r_playing <= 1'b0;
            r_end     <= END_RST;
            r_loop    <= 1'b0;
        end else begin
            r_v1      <= is_render;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_cnt     <= r_cnt + CNTW'(is_render) - CNTW'(out_acc);
            r_pos     <= n_pos;
            r_step    <= n_step;
            r_playing <= n_playing;
            if (r_v5) begin
                r_wp <= r_wp + (QAW + 1)'(1);
            end
            if (out_acc) begin
                r_rp <= r_rp + (QAW + 1)'(1);
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    REG_SAMPLE_LENGTH: r_end  <= n_end;
                    REG_LOOP_ENABLE:   r_loop <= i_cfg_data[0];
                    default: begin
                        // no other registers
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/isp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module isp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
